### hdl/tlsaw_pkg.sv
// tlsaw_pkg: shared types, codes and fixed widths for the triangular lattice walk stepper
// no dependencies; imported by every module of the block
`default_nettype none

package tlsaw_pkg;

    localparam int STEP_W      = 16;
    localparam int COORD_OUT_W = 8;
    localparam int DIR_W       = 3;
    localparam int NUM_DIRS    = 6;

    localparam logic [STEP_W-1:0] MAX_STEPS_RST = 16'd1024;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // direction codes and their lattice offsets
    localparam logic [DIR_W-1:0] DIR_XM    = 3'd0; // (-1, 0)
    localparam logic [DIR_W-1:0] DIR_XM_YP = 3'd1; // (-1,+1)
    localparam logic [DIR_W-1:0] DIR_YP    = 3'd2; // ( 0,+1)
    localparam logic [DIR_W-1:0] DIR_XP    = 3'd3; // (+1, 0)
    localparam logic [DIR_W-1:0] DIR_XP_YM = 3'd4; // (+1,-1)
    localparam logic [DIR_W-1:0] DIR_YM    = 3'd5; // ( 0,-1)

    typedef enum logic [2:0] {
        OUT_MOVED    = 3'd0,
        OUT_REJECTED = 3'd1,
        OUT_TRAPPED  = 3'd2,
        OUT_LIMIT    = 3'd3,
        OUT_STARTED  = 3'd4
    } t_outcome;

    typedef struct packed {
        logic             command;
        logic [DIR_W-1:0] direction;
    } t_in_item;

    typedef struct packed {
        t_outcome               outcome;
        logic [COORD_OUT_W-1:0] lattice_x;
        logic [COORD_OUT_W-1:0] lattice_y;
        logic [STEP_W-1:0]      step_index;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_LO,
        ST_RD_MID,
        ST_RD_HI,
        ST_CAP_HI,
        ST_DECIDE,
        ST_MARK_RD,
        ST_MARK_WR
    } t_state;

    // which bitmap row is read: below, at or above the walker
    typedef enum logic [1:0] {
        ROW_LO,
        ROW_MID,
        ROW_HI
    } t_row_sel;

    typedef struct packed {
        logic     accept;
        logic     clr_wr;
        logic     clr_mark;
        t_row_sel rd_sel;
        logic     cap_lo;
        logic     cap_mid;
        logic     cap_hi;
        logic     commit;
        logic     mark_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic in_start;
        logic clr_last;
        logic out_free;
        logic moved;
    } t_dp_sts;

endpackage

`default_nettype wire

### hdl/tlsaw_ctrl.sv
// tlsaw_ctrl: sequencer for clear sweeps, neighbour row reads, decision and cell marking
// depends on tlsaw_pkg
`default_nettype none

module tlsaw_ctrl import tlsaw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state r_state, n_state;
    logic   r_boot, n_boot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_boot       = r_boot;
        o_cmd        = '0;
        o_cmd.rd_sel = ROW_MID;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                // sweep after reset leaves the centre unmarked
                o_cmd.clr_wr   = 1'b1;
                o_cmd.clr_mark = !r_boot;
                if (i_sts.clr_last) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? ST_IDLE : ST_DECIDE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.in_start ? ST_CLEAR : ST_RD_LO;
                end
            end
            ST_RD_LO: begin
                o_cmd.rd_sel = ROW_LO;
                n_state      = ST_RD_MID;
            end
            ST_RD_MID: begin
                o_cmd.rd_sel = ROW_MID;
                o_cmd.cap_lo = 1'b1;
                n_state      = ST_RD_HI;
            end
            ST_RD_HI: begin
                o_cmd.rd_sel  = ROW_HI;
                o_cmd.cap_mid = 1'b1;
                n_state       = ST_CAP_HI;
            end
            ST_CAP_HI: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = i_sts.moved ? ST_MARK_RD : ST_IDLE;
                end
            end
            ST_MARK_RD: begin
                n_state = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/tlsaw_dpath.sv
// tlsaw_dpath: visited bitmap memory (one row per word), walker state, decision and result register
// depends on tlsaw_pkg; driven by tlsaw_ctrl
`default_nettype none

module tlsaw_dpath import tlsaw_pkg::*; #(
    parameter int LATTICE_SIDE = 256,
    parameter int START_COORD  = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_in_item,
    input  logic              i_cfg_we,
    input  logic [STEP_W-1:0] i_cfg_wdata,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output t_out_item         o_out_item
);

    localparam int CW = $clog2(LATTICE_SIDE);
    localparam logic [CW-1:0] START_POS = CW'(START_COORD % LATTICE_SIDE);
    localparam logic [CW-1:0] LAST_POS  = CW'(LATTICE_SIDE - 1);

    typedef logic [LATTICE_SIDE-1:0] t_row;

    // bitmap memory
    t_row          mem [LATTICE_SIDE];
    t_row          r_rd_data;
    logic [CW-1:0] rd_addr;
    logic [CW-1:0] wr_addr;
    t_row          wr_data;
    logic          wr_en;

    // walker state and config
    logic [CW-1:0]     r_x, r_y;
    logic [STEP_W-1:0] r_count;
    logic              r_ended;
    logic [STEP_W-1:0] r_max;
    logic [CW-1:0]     r_clr_row;

    // latched item and neighbour flags
    logic                r_cmd;
    logic [DIR_W-1:0]    r_dir;
    logic [NUM_DIRS-1:0] r_taken;

    logic          r_out_valid;
    t_out_item     r_out;

    logic [CW-1:0] x_m1, x_p1, y_m1, y_p1;
    logic          x_lo_ok, x_hi_ok, y_lo_ok, y_hi_ok;
    logic          bit_m1, bit_c, bit_p1;
    t_row          clr_data;
    t_row          x_onehot;
    logic          clr_last;

    logic                          all_taken, dir_ok, tgt_taken, moved;
    logic [CW-1:0]                 mv_x, mv_y, n_x, n_y;
    logic [STEP_W-1:0]             n_count;
    logic                          n_ended;
    t_outcome                      outcome;
    logic [CW+COORD_OUT_W-1:0]     x_ext, y_ext;
    logic                          out_free;

    assign x_m1    = r_x - 1'b1;
    assign x_p1    = r_x + 1'b1;
    assign y_m1    = r_y - 1'b1;
    assign y_p1    = r_y + 1'b1;
    assign x_lo_ok = (r_x != '0);
    assign x_hi_ok = (r_x != LAST_POS);
    assign y_lo_ok = (r_y != '0);
    assign y_hi_ok = (r_y != LAST_POS);

    always_comb begin
        case (i_cmd.rd_sel)
            ROW_LO:  rd_addr = y_lo_ok ? y_m1 : r_y;
            ROW_HI:  rd_addr = y_hi_ok ? y_p1 : r_y;
            default: rd_addr = r_y;
        endcase
    end

    assign x_onehot = {{(LATTICE_SIDE-1){1'b0}}, 1'b1} << r_x;
    assign clr_data = (i_cmd.clr_mark && (r_clr_row == START_POS))
                    ? ({{(LATTICE_SIDE-1){1'b0}}, 1'b1} << START_POS) : '0;
    assign clr_last = (r_clr_row == LAST_POS);

    assign wr_en   = i_cmd.clr_wr || i_cmd.mark_wr;
    assign wr_addr = i_cmd.clr_wr ? r_clr_row : r_y;
    assign wr_data = i_cmd.clr_wr ? clr_data : (r_rd_data | x_onehot);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_row <= clr_last ? '0 : r_clr_row + 1'b1;
        end
    end

    // cells beyond the edge read as visited
    assign bit_m1 = x_lo_ok ? r_rd_data[x_m1] : 1'b1;
    assign bit_c  = r_rd_data[r_x];
    assign bit_p1 = x_hi_ok ? r_rd_data[x_p1] : 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_in_item.command;
            r_dir <= i_in_item.direction;
        end
        if (i_cmd.cap_lo) begin
            r_taken[DIR_XP_YM] <= !y_lo_ok || bit_p1;
            r_taken[DIR_YM]    <= !y_lo_ok || bit_c;
        end
        if (i_cmd.cap_mid) begin
            r_taken[DIR_XM] <= bit_m1;
            r_taken[DIR_XP] <= bit_p1;
        end
        if (i_cmd.cap_hi) begin
            r_taken[DIR_XM_YP] <= !y_hi_ok || bit_m1;
            r_taken[DIR_YP]    <= !y_hi_ok || bit_c;
        end
    end

    assign all_taken = &r_taken;
    assign dir_ok    = (r_dir < DIR_W'(NUM_DIRS));
    assign tgt_taken = dir_ok ? r_taken[r_dir] : 1'b1;

    always_comb begin
        case (r_dir) inside
            DIR_XM, DIR_XM_YP: mv_x = x_m1;
            DIR_XP, DIR_XP_YM: mv_x = x_p1;
            default:           mv_x = r_x;
        endcase
        case (r_dir) inside
            DIR_XM_YP, DIR_YP: mv_y = y_p1;
            DIR_XP_YM, DIR_YM: mv_y = y_m1;
            default:           mv_y = r_y;
        endcase
    end

    // priority: start, ended walk, step limit, trapped, rejected, move
    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_count = r_count;
        n_ended = r_ended;
        moved   = 1'b0;
        outcome = OUT_REJECTED;
        if (r_cmd == CMD_START) begin
            n_x     = START_POS;
            n_y     = START_POS;
            n_count = '0;
            n_ended = 1'b0;
            outcome = OUT_STARTED;
        end else if (r_ended) begin
            outcome = ((r_count < r_max) && all_taken) ? OUT_TRAPPED : OUT_LIMIT;
        end else if (r_count >= r_max) begin
            n_ended = 1'b1;
            outcome = OUT_LIMIT;
        end else if (all_taken) begin
            n_ended = 1'b1;
            outcome = OUT_TRAPPED;
        end else if (tgt_taken) begin
            outcome = OUT_REJECTED;
        end else begin
            n_x     = mv_x;
            n_y     = mv_y;
            n_count = (r_count != '1) ? r_count + 1'b1 : r_count;
            moved   = 1'b1;
            outcome = OUT_MOVED;
        end
    end

    assign x_ext = {{COORD_OUT_W{1'b0}}, n_x};
    assign y_ext = {{COORD_OUT_W{1'b0}}, n_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= START_POS;
            r_y     <= START_POS;
            r_count <= '0;
            r_ended <= 1'b0;
            r_max   <= MAX_STEPS_RST;
        end else begin
            if (i_cmd.commit) begin
                r_x     <= n_x;
                r_y     <= n_y;
                r_count <= n_count;
                r_ended <= n_ended;
            end
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

    // result register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.outcome    <= outcome;
            r_out.lattice_x  <= x_ext[COORD_OUT_W-1:0];
            r_out.lattice_y  <= y_ext[COORD_OUT_W-1:0];
            r_out.step_index <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;
    assign o_sts.in_start = (i_in_item.command == CMD_START);
    assign o_sts.clr_last = clr_last;
    assign o_sts.out_free = out_free;
    assign o_sts.moved    = moved;

endmodule

`default_nettype wire

### hdl/triangular_lattice_self_avoiding_walk_top.sv
// self-avoiding walk stepper on a triangular lattice: top level
// input channel: i_in_valid / o_in_stall carry a command (start or step) and a direction
// output channel: o_out_valid / i_out_stall carry outcome, walker position and step count
// config: i_cfg_we / i_cfg_wdata write max_steps (reset 1024); the user must write it only
//   while the block is idle, a check that the block leaves to the user
// one result per accepted item, in order
// a step item closes the input until its work is done: three bitmap rows (below, at,
//   above the walker) are read one per cycle through the single memory read port, then
//   the decision waits for a free output register, and on a move the target row is read
//   back and rewritten to mark the new cell; the result is loaded at the decision
// a start item sweeps the bitmap one row per cycle, then goes to its decision
// after reset the bitmap is cleared the same way; no input transfer is taken until
//   the sweep ends
// when the receiver stalls the result stays in the output register; the next item is
//   still accepted and worked on, and waits at its decision until the register frees
`default_nettype none

module triangular_lattice_self_avoiding_walk_top import tlsaw_pkg::*; #(
    parameter int LATTICE_SIDE = 256,
    parameter int START_COORD  = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input item channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    // max_steps register
    input  logic              i_cfg_we,
    input  logic [STEP_W-1:0] i_cfg_wdata
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: clear sweep, row reads, decision, mark write-back
    tlsaw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    // bitmap, walker registers and result register
    tlsaw_dpath #(
        .LATTICE_SIDE (LATTICE_SIDE),
        .START_COORD  (START_COORD)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

### hdl/tlsaw_checker.sv
// tlsaw_checker: port-level assertions for the walk stepper, bound to the top level
// depends on tlsaw_pkg and triangular_lattice_self_avoiding_walk_top
`default_nettype none

module tlsaw_checker import tlsaw_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_item         o_out_item
);

    // one item in flight: a transfer closes the input until its work is done
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken in the cycle after a transfer");

    // a new walk always reports zero completed steps
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.outcome == OUT_STARTED)) |-> (o_out_item.step_index == '0))
        else $error("start result with non-zero step count");

    // a move always leaves at least one completed step
    a_move_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.outcome == OUT_MOVED)) |-> (o_out_item.step_index != '0))
        else $error("move result with zero step count");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result dropped or changed");

endmodule

bind triangular_lattice_self_avoiding_walk_top tlsaw_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
